// ===== rtl/core/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the polygon test block.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on every rising clock edge out of reset.
`define CPT_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on every rising clock edge out of reset.
`define CPT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/cpt_pkg.sv =====
// ----------------------------------------------------------------------------
// cpt_pkg
// Types, codes, constants and helpers shared by the polygon test modules.
// ----------------------------------------------------------------------------
package cpt_pkg;

    localparam int MAX_VERTICES_DEF = 32;
    localparam int CORDIC_STEPS_DEF = 16;

    localparam int DATA_W = 32;
    localparam int CDW    = 34;            // CORDIC and multiplier operand width
    localparam int PW     = 2 * CDW;       // product width
    localparam int ACC_W  = PW + 1;        // accumulator width
    localparam int STEP_W = 5;

    // Item commands.
    localparam logic [1:0] CMD_LOAD      = 2'd0;
    localparam logic [1:0] CMD_SCALE     = 2'd1;
    localparam logic [1:0] CMD_TRANSFORM = 2'd2;
    localparam logic [1:0] CMD_TEST      = 2'd3;

    // Multiplier operand selections.
    localparam logic [2:0] MS_SCX = 3'd0;
    localparam logic [2:0] MS_SCY = 3'd1;
    localparam logic [2:0] MS_XC  = 3'd2;
    localparam logic [2:0] MS_YS  = 3'd3;
    localparam logic [2:0] MS_XS  = 3'd4;
    localparam logic [2:0] MS_YC  = 3'd5;
    localparam logic [2:0] MS_EA  = 3'd6;
    localparam logic [2:0] MS_EB  = 3'd7;

    // Accumulator operations.
    localparam logic [1:0] ACC_HOLD = 2'd0;
    localparam logic [1:0] ACC_LOAD = 2'd1;
    localparam logic [1:0] ACC_ADD  = 2'd2;
    localparam logic [1:0] ACC_SUB  = 2'd3;

    localparam logic signed [15:0]    ANGLE_LIMIT = 16'sd25736;
    localparam logic signed [CDW-1:0] HALF_PI_Q30 = 34'sd1686629713;
    localparam logic signed [CDW-1:0] PI_Q30      = 34'sd3373259426;
    localparam logic signed [CDW-1:0] GAIN_Q30    = 34'sd652032874;

    typedef struct packed {
        logic              capture;
        logic              load_wr;
        logic              rd_local;
        logic              rd_world;
        logic              mul_en;
        logic [2:0]        mul_sel;
        logic [1:0]        acc_op;
        logic              scale_wr_x;
        logic              scale_wr_y;
        logic              rot_x_calc;
        logic              rot_y_calc;
        logic              world_wr;
        logic              box_first;
        logic              cordic_init;
        logic              cordic_step;
        logic              cordic_fin;
        logic [STEP_W-1:0] step;
        logic              take_first;
        logic              take_prev;
        logic              edge_prep;
        logic              edge_use_first;
        logic              out_load;
        logic              out_inside;
    } t_dp_cmd;

    typedef struct packed {
        logic [1:0] cmd;
        logic       load_ok;
        logic       acc_pos;
    } t_dp_status;

    // Arctangent of 2^-i in Q2.30.
    function automatic logic signed [CDW-1:0] atan_q30(input logic [STEP_W-1:0] i);
        logic signed [CDW-1:0] v;
        unique case (i)
            5'd0:  v = 34'sd843314857;
            5'd1:  v = 34'sd497837829;
            5'd2:  v = 34'sd263043837;
            5'd3:  v = 34'sd133525159;
            5'd4:  v = 34'sd67021687;
            5'd5:  v = 34'sd33543516;
            5'd6:  v = 34'sd16775851;
            5'd7:  v = 34'sd8388437;
            5'd8:  v = 34'sd4194283;
            5'd9:  v = 34'sd2097149;
            5'd10: v = 34'sd1048576;
            5'd11: v = 34'sd524288;
            5'd12: v = 34'sd262144;
            5'd13: v = 34'sd131072;
            5'd14: v = 34'sd65536;
            5'd15: v = 34'sd32768;
            5'd16: v = 34'sd16384;
            5'd17: v = 34'sd8192;
            5'd18: v = 34'sd4096;
            5'd19: v = 34'sd2048;
            5'd20: v = 34'sd1024;
            5'd21: v = 34'sd512;
            5'd22: v = 34'sd256;
            5'd23: v = 34'sd128;
            5'd24: v = 34'sd64;
            5'd25: v = 34'sd32;
            5'd26: v = 34'sd16;
            5'd27: v = 34'sd8;
            5'd28: v = 34'sd4;
            5'd29: v = 34'sd2;
            default: v = '0;
        endcase
        return v;
    endfunction

    // Saturates a wide signed value to 32 bits.
    function automatic logic signed [DATA_W-1:0] sat32(input logic signed [ACC_W-1:0] v);
        logic signed [DATA_W-1:0] r;
        if ((&v[ACC_W-1:DATA_W-1]) || !(|v[ACC_W-1:DATA_W-1])) begin
            r = v[DATA_W-1:0];
        end else if (v[ACC_W-1]) begin
            r = 32'sh8000_0000;
        end else begin
            r = 32'sh7FFF_FFFF;
        end
        return r;
    endfunction

endpackage

// ===== rtl/core/cpt_dpath.sv =====
// ----------------------------------------------------------------------------
// cpt_dpath
// Vertex stores, shared multiplier, accumulator, CORDIC and bounding box.
// ----------------------------------------------------------------------------
module cpt_dpath #(
    parameter int MAX_VERTICES = cpt_pkg::MAX_VERTICES_DEF,
    parameter int AW           = $clog2(MAX_VERTICES)
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic [1:0]            i_cmd,
    input  logic [4:0]            i_vertex_index,
    input  logic signed [31:0]    i_vertex_x,
    input  logic signed [31:0]    i_vertex_y,
    input  logic signed [31:0]    i_scale_x,
    input  logic signed [31:0]    i_scale_y,
    input  logic signed [31:0]    i_pos_x,
    input  logic signed [31:0]    i_pos_y,
    input  logic signed [15:0]    i_angle,
    input  logic signed [31:0]    i_point_x,
    input  logic signed [31:0]    i_point_y,
    input  cpt_pkg::t_dp_cmd      i_dp_cmd,
    input  logic [AW-1:0]         i_addr,
    output cpt_pkg::t_dp_status   o_status,
    output logic                  o_inside_res,
    output logic signed [31:0]    o_min_x,
    output logic signed [31:0]    o_min_y,
    output logic signed [31:0]    o_max_x,
    output logic signed [31:0]    o_max_y
);

    localparam int CDW   = cpt_pkg::CDW;
    localparam int PW    = cpt_pkg::PW;
    localparam int ACC_W = cpt_pkg::ACC_W;

    // Captured item.
    logic [1:0]         r_cmd;
    logic [4:0]         r_idx;
    logic signed [31:0] r_vx, r_vy, r_sx, r_sy, r_px, r_py, r_ptx, r_pty;
    logic signed [15:0] r_ang;

    logic signed [31:0] r_lx [MAX_VERTICES];
    logic signed [31:0] r_ly [MAX_VERTICES];
    logic signed [31:0] r_wx [MAX_VERTICES];
    logic signed [31:0] r_wy [MAX_VERTICES];
    logic signed [31:0] r_lrx, r_lry, r_wrx, r_wry;

    logic signed [CDW-1:0] r_cx, r_cy, r_cz, r_c, r_s;
    logic                  r_flip;

    logic signed [PW-1:0]    r_prod;
    logic signed [ACC_W-1:0] r_acc;
    logic signed [31:0]      r_wxv, r_wyv;
    logic signed [31:0]      r_fx, r_fy, r_prx, r_pry;
    logic signed [32:0]      r_ex, r_ey, r_dx, r_dy;
    logic signed [31:0]      r_bminx, r_bminy, r_bmaxx, r_bmaxy;

    logic signed [CDW-1:0] w_ma, w_mb;
    logic signed [15:0]    w_ang;
    logic signed [CDW-1:0] w_z0;
    logic signed [CDW-1:0] w_dx, w_dy, w_at;
    logic signed [31:0]    w_sc;
    logic signed [31:0]    w_nx, w_ny;
    logic [AW-1:0]         w_load_addr;

    assign w_load_addr = AW'(r_idx);
    assign o_status.cmd     = r_cmd;
    assign o_status.load_ok = (32'(r_idx) < MAX_VERTICES);
    assign o_status.acc_pos = !r_acc[ACC_W-1] && (|r_acc);

    always_ff @(posedge i_clk) begin
        if (i_dp_cmd.capture) begin
            r_cmd <= i_cmd;
            r_idx <= i_vertex_index;
            r_vx  <= i_vertex_x;
            r_vy  <= i_vertex_y;
            r_sx  <= i_scale_x;
            r_sy  <= i_scale_y;
            r_px  <= i_pos_x;
            r_py  <= i_pos_y;
            r_ang <= i_angle;
            r_ptx <= i_point_x;
            r_pty <= i_point_y;
        end
    end

    // Scaled value of the current product, Q16.16 after the shift.
    assign w_sc = cpt_pkg::sat32(ACC_W'(r_prod) >>> 16);

    // Local vertex store.
    always_ff @(posedge i_clk) begin
        if (i_dp_cmd.load_wr) begin
            r_lx[w_load_addr] <= r_vx;
        end else if (i_dp_cmd.scale_wr_x) begin
            r_lx[i_addr] <= w_sc;
        end
        if (i_dp_cmd.rd_local) begin
            r_lrx <= r_lx[i_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_dp_cmd.load_wr) begin
            r_ly[w_load_addr] <= r_vy;
        end else if (i_dp_cmd.scale_wr_y) begin
            r_ly[i_addr] <= w_sc;
        end
        if (i_dp_cmd.rd_local) begin
            r_lry <= r_ly[i_addr];
        end
    end

    // World vertex store.
    always_ff @(posedge i_clk) begin
        if (i_dp_cmd.world_wr) begin
            r_wx[i_addr] <= r_wxv;
            r_wy[i_addr] <= r_wyv;
        end
        if (i_dp_cmd.rd_world) begin
            r_wrx <= r_wx[i_addr];
            r_wry <= r_wy[i_addr];
        end
    end

    // CORDIC, one rotation step per cycle.
    always_comb begin
        if (r_ang > cpt_pkg::ANGLE_LIMIT) begin
            w_ang = cpt_pkg::ANGLE_LIMIT;
        end else if (r_ang < -cpt_pkg::ANGLE_LIMIT) begin
            w_ang = -cpt_pkg::ANGLE_LIMIT;
        end else begin
            w_ang = r_ang;
        end
    end

    assign w_z0 = CDW'(w_ang) <<< 17;
    assign w_dx = r_cy >>> i_dp_cmd.step;
    assign w_dy = r_cx >>> i_dp_cmd.step;
    assign w_at = cpt_pkg::atan_q30(i_dp_cmd.step);

    always_ff @(posedge i_clk) begin
        if (i_dp_cmd.cordic_init) begin
            r_cx <= cpt_pkg::GAIN_Q30;
            r_cy <= '0;
            if (w_z0 > cpt_pkg::HALF_PI_Q30) begin
                r_cz   <= w_z0 - cpt_pkg::PI_Q30;
                r_flip <= 1'b1;
            end else if (w_z0 < -cpt_pkg::HALF_PI_Q30) begin
                r_cz   <= w_z0 + cpt_pkg::PI_Q30;
                r_flip <= 1'b1;
            end else begin
                r_cz   <= w_z0;
                r_flip <= 1'b0;
            end
        end else if (i_dp_cmd.cordic_step) begin
            if (!r_cz[CDW-1]) begin
                r_cx <= r_cx - w_dx;
                r_cy <= r_cy + w_dy;
                r_cz <= r_cz - w_at;
            end else begin
                r_cx <= r_cx + w_dx;
                r_cy <= r_cy - w_dy;
                r_cz <= r_cz + w_at;
            end
        end
        if (i_dp_cmd.cordic_fin) begin
            r_c <= r_flip ? -r_cx : r_cx;
            r_s <= r_flip ? -r_cy : r_cy;
        end
    end

    // Shared multiplier.
    always_comb begin
        unique case (i_dp_cmd.mul_sel)
            cpt_pkg::MS_SCX: begin w_ma = CDW'(r_lrx); w_mb = CDW'(r_sx); end
            cpt_pkg::MS_SCY: begin w_ma = CDW'(r_lry); w_mb = CDW'(r_sy); end
            cpt_pkg::MS_XC:  begin w_ma = CDW'(r_lrx); w_mb = r_c; end
            cpt_pkg::MS_YS:  begin w_ma = CDW'(r_lry); w_mb = r_s; end
            cpt_pkg::MS_XS:  begin w_ma = CDW'(r_lrx); w_mb = r_s; end
            cpt_pkg::MS_YC:  begin w_ma = CDW'(r_lry); w_mb = r_c; end
            cpt_pkg::MS_EA:  begin w_ma = CDW'(r_ey);  w_mb = CDW'(r_dx); end
            cpt_pkg::MS_EB:  begin w_ma = CDW'(r_ex);  w_mb = CDW'(r_dy); end
            default:         begin w_ma = '0;          w_mb = '0; end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_dp_cmd.mul_en) begin
            r_prod <= PW'(w_ma) * PW'(w_mb);
        end
        unique case (i_dp_cmd.acc_op)
            cpt_pkg::ACC_LOAD: r_acc <= ACC_W'(r_prod);
            cpt_pkg::ACC_ADD:  r_acc <= r_acc + ACC_W'(r_prod);
            cpt_pkg::ACC_SUB:  r_acc <= r_acc - ACC_W'(r_prod);
            default:           r_acc <= r_acc;
        endcase
        if (i_dp_cmd.rot_x_calc) begin
            r_wxv <= cpt_pkg::sat32((r_acc >>> 30) + ACC_W'(r_px));
        end
        if (i_dp_cmd.rot_y_calc) begin
            r_wyv <= cpt_pkg::sat32((r_acc >>> 30) + ACC_W'(r_py));
        end
    end

    // Edge operands: the edge runs from the previous vertex to the next one.
    assign w_nx = i_dp_cmd.edge_use_first ? r_fx : r_wrx;
    assign w_ny = i_dp_cmd.edge_use_first ? r_fy : r_wry;

    always_ff @(posedge i_clk) begin
        if (i_dp_cmd.take_first) begin
            r_fx  <= r_wrx;
            r_fy  <= r_wry;
            r_prx <= r_wrx;
            r_pry <= r_wry;
        end else if (i_dp_cmd.take_prev) begin
            r_prx <= r_wrx;
            r_pry <= r_wry;
        end
        if (i_dp_cmd.edge_prep) begin
            r_ex <= 33'(w_nx) - 33'(r_prx);
            r_ey <= 33'(w_ny) - 33'(r_pry);
            r_dx <= 33'(r_ptx) - 33'(r_prx);
            r_dy <= 33'(r_pty) - 33'(r_pry);
        end
    end

    // Bounding box.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bminx <= '0;
            r_bminy <= '0;
            r_bmaxx <= '0;
            r_bmaxy <= '0;
        end else if (i_dp_cmd.world_wr) begin
            if (i_dp_cmd.box_first) begin
                r_bminx <= r_wxv;
                r_bmaxx <= r_wxv;
                r_bminy <= r_wyv;
                r_bmaxy <= r_wyv;
            end else begin
                if (r_wxv < r_bminx) r_bminx <= r_wxv;
                if (r_wxv > r_bmaxx) r_bmaxx <= r_wxv;
                if (r_wyv < r_bminy) r_bminy <= r_wyv;
                if (r_wyv > r_bmaxy) r_bmaxy <= r_wyv;
            end
        end
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (i_dp_cmd.out_load) begin
            o_inside_res <= i_dp_cmd.out_inside;
            o_min_x      <= r_bminx;
            o_min_y      <= r_bminy;
            o_max_x      <= r_bmaxx;
            o_max_y      <= r_bmaxy;
        end
    end

endmodule

// ===== rtl/core/cpt_ctrl.sv =====
// ----------------------------------------------------------------------------
// cpt_ctrl
// Sequencer for load, scale, transform and test items and the result beat.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module cpt_ctrl #(
    parameter int MAX_VERTICES = cpt_pkg::MAX_VERTICES_DEF,
    parameter int CORDIC_STEPS = cpt_pkg::CORDIC_STEPS_DEF,
    parameter int AW           = $clog2(MAX_VERTICES)
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_stall,
    input  logic                 i_cfg_valid,
    input  logic [5:0]           i_cfg_data,
    output logic                 o_cfg_ready,
    output logic                 o_valid,
    input  logic                 i_stall,
    input  cpt_pkg::t_dp_status  i_status,
    output cpt_pkg::t_dp_cmd     o_dp_cmd,
    output logic [AW-1:0]        o_addr
);

    localparam int CW = $clog2(MAX_VERTICES + 1);
    localparam int SW = cpt_pkg::STEP_W;

    localparam logic [4:0] S_IDLE    = 5'd0;
    localparam logic [4:0] S_DISP    = 5'd1;
    localparam logic [4:0] S_SC_RD   = 5'd2;
    localparam logic [4:0] S_SC_MX   = 5'd3;
    localparam logic [4:0] S_SC_MY   = 5'd4;
    localparam logic [4:0] S_SC_WY   = 5'd5;
    localparam logic [4:0] S_CO_INIT = 5'd6;
    localparam logic [4:0] S_CO_STEP = 5'd7;
    localparam logic [4:0] S_CO_FIN  = 5'd8;
    localparam logic [4:0] S_RT_RD   = 5'd9;
    localparam logic [4:0] S_RT_M1   = 5'd10;
    localparam logic [4:0] S_RT_M2   = 5'd11;
    localparam logic [4:0] S_RT_M3   = 5'd12;
    localparam logic [4:0] S_RT_M4   = 5'd13;
    localparam logic [4:0] S_RT_M5   = 5'd14;
    localparam logic [4:0] S_RT_WY   = 5'd15;
    localparam logic [4:0] S_RT_WR   = 5'd16;
    localparam logic [4:0] S_TS_RD0  = 5'd17;
    localparam logic [4:0] S_TS_F    = 5'd18;
    localparam logic [4:0] S_TS_RD   = 5'd19;
    localparam logic [4:0] S_TS_PREP = 5'd20;
    localparam logic [4:0] S_TS_MA   = 5'd21;
    localparam logic [4:0] S_TS_MB   = 5'd22;
    localparam logic [4:0] S_TS_CMP  = 5'd23;
    localparam logic [4:0] S_TS_CHK  = 5'd24;
    localparam logic [4:0] S_FIN     = 5'd25;

    logic [4:0]    r_state, n_state;
    logic [AW-1:0] r_k, n_k;
    logic [SW-1:0] r_step, n_step;
    logic          r_wrap, n_wrap;
    logic          r_inside, n_inside;
    logic [5:0]    r_vcount;
    logic [CW-1:0] r_wcount, n_wcount;
    logic          r_out_valid, n_out_valid;

    logic [CW-1:0] w_n;
    logic          w_last_n, w_last_w;

    assign w_n      = (32'(r_vcount) > MAX_VERTICES) ? CW'(MAX_VERTICES) : CW'(r_vcount);
    assign w_last_n = (CW'(r_k) + CW'(1)) == w_n;
    assign w_last_w = (CW'(r_k) + CW'(1)) == r_wcount;

    assign o_stall     = (r_state != S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign o_valid     = r_out_valid;
    assign o_addr      = r_k;

    always_comb begin
        n_state     = r_state;
        n_k         = r_k;
        n_step      = r_step;
        n_wrap      = r_wrap;
        n_inside    = r_inside;
        n_wcount    = r_wcount;
        n_out_valid = r_out_valid && i_stall;
        o_dp_cmd    = '0;

        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_dp_cmd.capture = 1'b1;
                    n_state = S_DISP;
                end
            end
            S_DISP: begin
                n_inside = 1'b0;
                n_k      = '0;
                n_wrap   = 1'b0;
                n_step   = '0;
                unique case (i_status.cmd)
                    cpt_pkg::CMD_LOAD: begin
                        o_dp_cmd.load_wr = i_status.load_ok;
                        n_state = S_FIN;
                    end
                    cpt_pkg::CMD_SCALE: begin
                        n_state = (w_n == '0) ? S_FIN : S_SC_RD;
                    end
                    cpt_pkg::CMD_TRANSFORM: begin
                        o_dp_cmd.cordic_init = 1'b1;
                        n_state = S_CO_STEP;
                    end
                    default: begin
                        if (r_wcount == '0) begin
                            n_inside = 1'b1;
                            n_state  = S_FIN;
                        end else begin
                            n_state = S_TS_RD0;
                        end
                    end
                endcase
            end
            S_SC_RD: begin
                o_dp_cmd.rd_local = 1'b1;
                n_state = S_SC_MX;
            end
            S_SC_MX: begin
                o_dp_cmd.mul_en  = 1'b1;
                o_dp_cmd.mul_sel = cpt_pkg::MS_SCX;
                n_state = S_SC_MY;
            end
            S_SC_MY: begin
                o_dp_cmd.scale_wr_x = 1'b1;
                o_dp_cmd.mul_en     = 1'b1;
                o_dp_cmd.mul_sel    = cpt_pkg::MS_SCY;
                n_state = S_SC_WY;
            end
            S_SC_WY: begin
                o_dp_cmd.scale_wr_y = 1'b1;
                if (w_last_n) begin
                    n_state = S_FIN;
                end else begin
                    n_k     = r_k + AW'(1);
                    n_state = S_SC_RD;
                end
            end
            S_CO_INIT: begin
                o_dp_cmd.cordic_init = 1'b1;
                n_state = S_CO_STEP;
            end
            S_CO_STEP: begin
                o_dp_cmd.cordic_step = 1'b1;
                o_dp_cmd.step        = r_step;
                if (r_step == SW'(CORDIC_STEPS - 1)) begin
                    n_state = S_CO_FIN;
                end else begin
                    n_step = r_step + SW'(1);
                end
            end
            S_CO_FIN: begin
                o_dp_cmd.cordic_fin = 1'b1;
                n_wcount = w_n;
                n_state  = (w_n == '0) ? S_FIN : S_RT_RD;
            end
            S_RT_RD: begin
                o_dp_cmd.rd_local = 1'b1;
                n_state = S_RT_M1;
            end
            S_RT_M1: begin
                o_dp_cmd.mul_en  = 1'b1;
                o_dp_cmd.mul_sel = cpt_pkg::MS_XC;
                n_state = S_RT_M2;
            end
            S_RT_M2: begin
                o_dp_cmd.acc_op  = cpt_pkg::ACC_LOAD;
                o_dp_cmd.mul_en  = 1'b1;
                o_dp_cmd.mul_sel = cpt_pkg::MS_YS;
                n_state = S_RT_M3;
            end
            S_RT_M3: begin
                o_dp_cmd.acc_op  = cpt_pkg::ACC_SUB;
                o_dp_cmd.mul_en  = 1'b1;
                o_dp_cmd.mul_sel = cpt_pkg::MS_XS;
                n_state = S_RT_M4;
            end
            S_RT_M4: begin
                o_dp_cmd.rot_x_calc = 1'b1;
                o_dp_cmd.acc_op     = cpt_pkg::ACC_LOAD;
                o_dp_cmd.mul_en     = 1'b1;
                o_dp_cmd.mul_sel    = cpt_pkg::MS_YC;
                n_state = S_RT_M5;
            end
            S_RT_M5: begin
                o_dp_cmd.acc_op = cpt_pkg::ACC_ADD;
                n_state = S_RT_WY;
            end
            S_RT_WY: begin
                o_dp_cmd.rot_y_calc = 1'b1;
                n_state = S_RT_WR;
            end
            S_RT_WR: begin
                o_dp_cmd.world_wr  = 1'b1;
                o_dp_cmd.box_first = (r_k == '0);
                if (w_last_n) begin
                    n_state = S_FIN;
                end else begin
                    n_k     = r_k + AW'(1);
                    n_state = S_RT_RD;
                end
            end
            S_TS_RD0: begin
                o_dp_cmd.rd_world = 1'b1;
                n_state = S_TS_F;
            end
            S_TS_F: begin
                o_dp_cmd.take_first = 1'b1;
                if (w_last_w) begin
                    n_wrap  = 1'b1;
                    n_state = S_TS_PREP;
                end else begin
                    n_k     = r_k + AW'(1);
                    n_state = S_TS_RD;
                end
            end
            S_TS_RD: begin
                o_dp_cmd.rd_world = 1'b1;
                n_state = S_TS_PREP;
            end
            S_TS_PREP: begin
                o_dp_cmd.edge_prep      = 1'b1;
                o_dp_cmd.edge_use_first = r_wrap;
                n_state = S_TS_MA;
            end
            S_TS_MA: begin
                o_dp_cmd.mul_en  = 1'b1;
                o_dp_cmd.mul_sel = cpt_pkg::MS_EA;
                n_state = S_TS_MB;
            end
            S_TS_MB: begin
                o_dp_cmd.acc_op  = cpt_pkg::ACC_LOAD;
                o_dp_cmd.mul_en  = 1'b1;
                o_dp_cmd.mul_sel = cpt_pkg::MS_EB;
                n_state = S_TS_CMP;
            end
            S_TS_CMP: begin
                o_dp_cmd.acc_op = cpt_pkg::ACC_SUB;
                n_state = S_TS_CHK;
            end
            S_TS_CHK: begin
                if (i_status.acc_pos) begin
                    n_inside = 1'b0;
                    n_state  = S_FIN;
                end else if (r_wrap) begin
                    n_inside = 1'b1;
                    n_state  = S_FIN;
                end else begin
                    o_dp_cmd.take_prev = 1'b1;
                    if (w_last_w) begin
                        n_wrap  = 1'b1;
                        n_state = S_TS_PREP;
                    end else begin
                        n_k     = r_k + AW'(1);
                        n_state = S_TS_RD;
                    end
                end
            end
            S_FIN: begin
                if (!r_out_valid || !i_stall) begin
                    o_dp_cmd.out_load   = 1'b1;
                    o_dp_cmd.out_inside = r_inside;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_k         <= '0;
            r_step      <= '0;
            r_wrap      <= 1'b0;
            r_inside    <= 1'b0;
            r_wcount    <= '0;
            r_out_valid <= 1'b0;
            r_vcount    <= '0;
        end else begin
            r_state     <= n_state;
            r_k         <= n_k;
            r_step      <= n_step;
            r_wrap      <= n_wrap;
            r_inside    <= n_inside;
            r_wcount    <= n_wcount;
            r_out_valid <= n_out_valid;
            if (i_cfg_valid) begin
                r_vcount <= i_cfg_data;
            end
        end
    end

    `CPT_ASSERT_NOW(a_out_slot_free, i_clk, i_rst_n, o_dp_cmd.out_load,
        !r_out_valid || !i_stall, "result loaded over an unaccepted beat")
    `CPT_ASSERT_NEXT(a_accept_dispatch, i_clk, i_rst_n, i_valid && !o_stall,
        r_state == S_DISP, "accepted item did not reach dispatch")
    `CPT_ASSERT_NOW(a_world_index, i_clk, i_rst_n, r_state == S_RT_WR,
        CW'(r_k) < w_n, "world write index beyond vertex count")
    `CPT_ASSERT_NOW(a_edge_index, i_clk, i_rst_n, r_state == S_TS_CHK,
        CW'(r_k) < r_wcount, "edge walk index beyond world count")

endmodule

// ===== rtl/core/convex_polygon_point_test.sv =====
// ----------------------------------------------------------------------------
// convex_polygon_point_test
// Convex polygon store with scale, rotate/translate and point inclusion test.
// ----------------------------------------------------------------------------
// The block takes one item at a time and returns exactly one result beat per
// item. With n the vertex count in use, a scale or transform works through
// the n vertices one after another, a transform after its CORDIC steps, and
// a test walks the edges from the first vertex, stops early at the first
// edge that rejects the point and, with no world vertices, reports the point
// inside without a walk. An item waits at its end while the previous result
// beat is still held downstream. The cost of each item is set by the single
// shared multiplier, which every vertex and every edge passes through two or
// four times, and by the single read port of each vertex store. A new item is
// taken as soon as the sequencer is idle, even while the previous result beat
// is still waiting downstream.
module convex_polygon_point_test #(
    parameter int MAX_VERTICES = cpt_pkg::MAX_VERTICES_DEF,
    parameter int CORDIC_STEPS = cpt_pkg::CORDIC_STEPS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // Item channel.
    input  logic               i_valid,
    output logic               o_stall,
    input  logic [1:0]         i_cmd,
    input  logic [4:0]         i_vertex_index,
    input  logic signed [31:0] i_vertex_x,
    input  logic signed [31:0] i_vertex_y,
    input  logic signed [31:0] i_scale_x,
    input  logic signed [31:0] i_scale_y,
    input  logic signed [31:0] i_pos_x,
    input  logic signed [31:0] i_pos_y,
    input  logic signed [15:0] i_angle,
    input  logic signed [31:0] i_point_x,
    input  logic signed [31:0] i_point_y,
    // Configuration channel: the vertex count register.
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [5:0]         i_cfg_data,
    // Result channel.
    output logic               o_valid,
    input  logic               i_stall,
    output logic               o_inside_res,
    output logic signed [31:0] o_min_x,
    output logic signed [31:0] o_min_y,
    output logic signed [31:0] o_max_x,
    output logic signed [31:0] o_max_y
);

    // Address width of the vertex stores.
    localparam int AW = $clog2(MAX_VERTICES);

    // The controller steps through each command and drives the datapath with
    // one command word per cycle; the datapath reports the captured command,
    // the load range check and the sign of the edge test back.
    cpt_pkg::t_dp_cmd    w_dp_cmd;
    cpt_pkg::t_dp_status w_status;
    logic [AW-1:0]       w_addr;

    cpt_ctrl #(
        .MAX_VERTICES (MAX_VERTICES),
        .CORDIC_STEPS (CORDIC_STEPS),
        .AW           (AW)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_data  (i_cfg_data),
        .o_cfg_ready (o_cfg_ready),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .i_status    (w_status),
        .o_dp_cmd    (w_dp_cmd),
        .o_addr      (w_addr)
    );

    // The datapath holds both vertex stores, the CORDIC, the multiplier and
    // accumulator, the bounding box and the result register.
    cpt_dpath #(
        .MAX_VERTICES (MAX_VERTICES),
        .AW           (AW)
    ) u_dpath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (i_cmd),
        .i_vertex_index (i_vertex_index),
        .i_vertex_x     (i_vertex_x),
        .i_vertex_y     (i_vertex_y),
        .i_scale_x      (i_scale_x),
        .i_scale_y      (i_scale_y),
        .i_pos_x        (i_pos_x),
        .i_pos_y        (i_pos_y),
        .i_angle        (i_angle),
        .i_point_x      (i_point_x),
        .i_point_y      (i_point_y),
        .i_dp_cmd       (w_dp_cmd),
        .i_addr         (w_addr),
        .o_status       (w_status),
        .o_inside_res   (o_inside_res),
        .o_min_x        (o_min_x),
        .o_min_y        (o_min_y),
        .o_max_x        (o_max_x),
        .o_max_y        (o_max_y)
    );

endmodule

// ===== test/convex_polygon_point_test_test.sv =====
// ----------------------------------------------------------------------------
// convex_polygon_point_test_test
// Self-checking bench for the convex polygon point test block: a short table
// of directed beats, then random convex polygons that are scaled, rotated,
// moved and probed, all checked against a cycle-free model of the block.
// ----------------------------------------------------------------------------
module convex_polygon_point_test_test;

    localparam int NV      = 32;
    localparam int STEPS   = 16;
    localparam int WD_MAX  = 6000;   // cycles without any accepted beat
    localparam int HOLD_LEN = 400;   // long downstream hold-off

    typedef struct {
        logic [1:0]         cmd;
        logic [4:0]         idx;
        logic signed [31:0] vx, vy, sx, sy, px, py, qx, qy;
        logic signed [15:0] ang;
    } item_t;

    typedef struct {
        bit                 hit;
        logic signed [31:0] mnx, mny, mxx, mxy;
    } box_res_t;

    typedef struct {
        item_t    it;
        bit       known;
        box_res_t res;
    } row_t;

    logic               i_clk, i_rst_n;
    logic               i_valid, o_stall;
    logic [1:0]         i_cmd;
    logic [4:0]         i_vertex_index;
    logic signed [31:0] i_vertex_x, i_vertex_y, i_scale_x, i_scale_y;
    logic signed [31:0] i_pos_x, i_pos_y, i_point_x, i_point_y;
    logic signed [15:0] i_angle;
    logic               i_cfg_valid, o_cfg_ready;
    logic [5:0]         i_cfg_data;
    logic               o_valid, i_stall, o_inside_res;
    logic signed [31:0] o_min_x, o_min_y, o_max_x, o_max_y;

    convex_polygon_point_test i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .o_stall(o_stall),
        .i_cmd(i_cmd), .i_vertex_index(i_vertex_index),
        .i_vertex_x(i_vertex_x), .i_vertex_y(i_vertex_y),
        .i_scale_x(i_scale_x), .i_scale_y(i_scale_y),
        .i_pos_x(i_pos_x), .i_pos_y(i_pos_y), .i_angle(i_angle),
        .i_point_x(i_point_x), .i_point_y(i_point_y),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready),
        .i_cfg_data(i_cfg_data),
        .o_valid(o_valid), .i_stall(i_stall), .o_inside_res(o_inside_res),
        .o_min_x(o_min_x), .o_min_y(o_min_y), .o_max_x(o_max_x), .o_max_y(o_max_y)
    );

    // Shadow copy of the polygon store, the world vertices and the box.
    longint             loc_x[NV], loc_y[NV], wld_x[NV], wld_y[NV];
    bit                 loc_written[NV];
    int                 wld_count;
    logic [5:0]         vert_count;
    logic signed [31:0] bb_mnx, bb_mny, bb_mxx, bb_mxy;

    box_res_t pending_boxes[$];
    row_t     table_rows[$];
    int       errors;
    bit       quiet;      // no random idling on either side
    bit       hold_req;   // asks the receiver for one long hold-off

    const longint atan_tab[STEPS] = '{
        843314857, 497837829, 263043837, 133525159, 67021687, 33543516,
        16775851, 8388437, 4194283, 2097149, 1048576, 524288, 262144, 131072,
        65536, 32768};

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    function automatic logic signed [31:0] clamp32(longint v);
        if (v > 64'sd2147483647) return 32'sh7FFF_FFFF;
        if (v < -64'sd2147483648) return 32'sh8000_0000;
        return v[31:0];
    endfunction

    function automatic int used_count();
        return (vert_count > NV) ? NV : int'(vert_count);
    endfunction

    // Sine and cosine in Q2.30. Angles past a quarter turn are folded by a
    // half turn and the signs restored afterwards.
    task automatic sin_cos(input logic signed [15:0] a, output longint c,
                           output longint s);
        longint ang, z, x, y, dx, dy;
        bit     flip;
        ang  = a;
        x    = 652032874;
        y    = 0;
        flip = 0;
        if (ang > 25736) ang = 25736;
        if (ang < -25736) ang = -25736;
        z = ang * 131072;
        if (z > 64'sd1686629713) begin
            z -= 64'sd3373259426;
            flip = 1;
        end else if (z < -64'sd1686629713) begin
            z += 64'sd3373259426;
            flip = 1;
        end
        for (int i = 0; i < STEPS; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0) begin
                x -= dx; y += dy; z -= atan_tab[i];
            end else begin
                x += dx; y -= dy; z += atan_tab[i];
            end
        end
        c = flip ? -x : x;
        s = flip ? -y : y;
    endtask

    function automatic bit point_inside(logic signed [31:0] qx, logic signed [31:0] qy);
        logic signed [67:0] ex, ey, dx, dy;
        int j;
        for (int i = 0; i < wld_count; i++) begin
            j  = (i + 1 == wld_count) ? 0 : i + 1;
            ex = 68'(wld_x[j] - wld_x[i]);
            ey = 68'(wld_y[j] - wld_y[i]);
            dx = 68'(longint'(qx) - wld_x[i]);
            dy = 68'(longint'(qy) - wld_y[i]);
            // Only the sign matters; an edge of zero length never rejects.
            if (ey * dx > ex * dy) return 1'b0;
        end
        return 1'b1;
    endfunction

    // Applies one item to the shadow state and returns the beat it yields.
    task automatic apply_item(input item_t it, output box_res_t r);
        int     n;
        longint c, s;
        n = used_count();
        r.hit = 1'b0;
        case (it.cmd)
            cpt_pkg::CMD_LOAD: begin
                loc_x[it.idx] = longint'(it.vx);
                loc_y[it.idx] = longint'(it.vy);
                loc_written[it.idx] = 1;
            end
            cpt_pkg::CMD_SCALE: begin
                for (int i = 0; i < n; i++) begin
                    loc_x[i] = longint'(clamp32((loc_x[i] * longint'(it.sx)) >>> 16));
                    loc_y[i] = longint'(clamp32((loc_y[i] * longint'(it.sy)) >>> 16));
                end
            end
            cpt_pkg::CMD_TRANSFORM: begin
                sin_cos(it.ang, c, s);
                for (int i = 0; i < n; i++) begin
                    wld_x[i] = longint'(clamp32(((loc_x[i] * c - loc_y[i] * s) >>> 30)
                                                + longint'(it.px)));
                    wld_y[i] = longint'(clamp32(((loc_x[i] * s + loc_y[i] * c) >>> 30)
                                                + longint'(it.py)));
                end
                wld_count = n;
                // With no vertices in use the box keeps its old corners.
                if (n > 0) begin
                    bb_mnx = 32'(wld_x[0]); bb_mxx = 32'(wld_x[0]);
                    bb_mny = 32'(wld_y[0]); bb_mxy = 32'(wld_y[0]);
                    for (int i = 1; i < n; i++) begin
                        if (wld_x[i] < bb_mnx) bb_mnx = 32'(wld_x[i]);
                        if (wld_x[i] > bb_mxx) bb_mxx = 32'(wld_x[i]);
                        if (wld_y[i] < bb_mny) bb_mny = 32'(wld_y[i]);
                        if (wld_y[i] > bb_mxy) bb_mxy = 32'(wld_y[i]);
                    end
                end
            end
            default: r.hit = point_inside(it.qx, it.qy);
        endcase
        r.mnx = bb_mnx; r.mny = bb_mny; r.mxx = bb_mxx; r.mxy = bb_mxy;
    endtask

    function automatic item_t make_item(logic [1:0] cmd, logic [4:0] idx,
                                        logic signed [31:0] a, logic signed [31:0] b,
                                        logic signed [15:0] ang);
        item_t it;
        // Fields that the command does not use carry random bits.
        it.idx = 5'($urandom); it.vx = $urandom; it.vy = $urandom;
        it.sx = $urandom; it.sy = $urandom; it.px = $urandom; it.py = $urandom;
        it.qx = $urandom; it.qy = $urandom; it.ang = 16'($urandom);
        it.cmd = cmd;
        case (cmd)
            cpt_pkg::CMD_LOAD: begin it.idx = idx; it.vx = a; it.vy = b; end
            cpt_pkg::CMD_SCALE: begin it.sx = a; it.sy = b; end
            cpt_pkg::CMD_TRANSFORM: begin it.px = a; it.py = b; it.ang = ang; end
            default: begin it.qx = a; it.qy = b; end
        endcase
        return it;
    endfunction

    function automatic int first_unwritten();
        for (int i = 0; i < used_count(); i++)
            if (!loc_written[i]) return i;
        return -1;
    endfunction

    // Sends one beat and records what it should yield. A scale or transform
    // that would touch a vertex never loaded turns into a load of it.
    task automatic send_beat(input item_t it, input bit known, input box_res_t typed);
        box_res_t r;
        int       hole;
        hole = first_unwritten();
        if ((it.cmd == cpt_pkg::CMD_SCALE || it.cmd == cpt_pkg::CMD_TRANSFORM) && hole >= 0)
            it = make_item(cpt_pkg::CMD_LOAD, 5'(hole), $urandom, $urandom, 0);
        if (!quiet && $urandom_range(0, 3) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge i_clk);
        end
        i_cmd <= it.cmd; i_vertex_index <= it.idx;
        i_vertex_x <= it.vx; i_vertex_y <= it.vy;
        i_scale_x <= it.sx; i_scale_y <= it.sy;
        i_pos_x <= it.px; i_pos_y <= it.py; i_angle <= it.ang;
        i_point_x <= it.qx; i_point_y <= it.qy;
        i_valid <= 1'b1;
        do @(posedge i_clk); while (o_stall);
        apply_item(it, r);
        pending_boxes.push_back(known ? typed : r);
    endtask

    // Writes the vertex count once the block has drained.
    task automatic write_count(input logic [5:0] v);
        i_valid <= 1'b0;
        wait (pending_boxes.size() == 0);
        @(posedge i_clk);
        i_cfg_data  <= v;
        i_cfg_valid <= 1'b1;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        vert_count = v;
    endtask

    task automatic add_row(input item_t it, input bit known, input bit hit,
                           input logic signed [31:0] box);
        row_t r;
        r.it = it; r.known = known; r.res.hit = hit;
        r.res.mnx = box; r.res.mny = box; r.res.mxx = box; r.res.mxy = box;
        table_rows.push_back(r);
    endtask

    // Random convex polygon: n points on a circle, spread over one full turn in
    // equal steps, found with the same sine and cosine as the block.
    task automatic load_polygon(input int n);
        longint c, s, rad;
        logic signed [15:0] a;
        box_res_t dummy;
        rad = longint'($urandom_range(1 << 16, 1 << 24));
        for (int k = 0; k < n; k++) begin
            a = 16'(-25736 + (k * 51472) / n);
            sin_cos(a, c, s);
            send_beat(make_item(cpt_pkg::CMD_LOAD, 5'(k), clamp32((rad * c) >>> 30),
                                clamp32((rad * s) >>> 30), 0), 0, dummy);
        end
    endtask

    task automatic random_phase(input logic [5:0] count, input int beats);
        box_res_t dummy;
        longint   w, h;
        int       pick;
        item_t    it;
        write_count(count);
        load_polygon(used_count());
        for (int k = 0; k < beats; k++) begin
            pick = $urandom_range(0, 99);
            w = longint'(bb_mxx) - bb_mnx + 1;
            h = longint'(bb_mxy) - bb_mny + 1;
            if (pick < 45) begin
                // Points around the box, many of them inside it.
                it = make_item(cpt_pkg::CMD_TEST, 0,
                    clamp32(bb_mnx - w / 4 + longint'($urandom) % (w + w / 2)),
                    clamp32(bb_mny - h / 4 + longint'($urandom) % (h + h / 2)), 0);
            end else if (pick < 65) begin
                it = make_item(cpt_pkg::CMD_TRANSFORM, 0,
                    $signed($urandom_range(0, 1 << 21)) - (1 << 20),
                    $signed($urandom_range(0, 1 << 21)) - (1 << 20),
                    ($urandom_range(0, 9) == 0) ? 16'($urandom)
                        : 16'($signed($urandom_range(0, 51472)) - 25736));
            end else if (pick < 75) begin
                it = ($urandom_range(0, 4) == 0)
                    ? make_item(cpt_pkg::CMD_SCALE, 0, $urandom, $urandom, 0)
                    : make_item(cpt_pkg::CMD_SCALE, 0, $urandom_range(32768, 131072),
                                $urandom_range(32768, 131072), 0);
            end else if (pick < 85) begin
                it = make_item(cpt_pkg::CMD_LOAD, 5'($urandom), $urandom, $urandom, 0);
            end else begin
                it = make_item(2'($urandom), 5'($urandom), $urandom, $urandom,
                               16'($urandom));
            end
            send_beat(it, 0, dummy);
        end
    endtask

    // Stimulus.
    initial begin
        box_res_t dummy;
        int       i;
        i_rst_n = 1'b0; i_valid = 1'b0; i_stall = 1'b0;
        i_cfg_valid = 1'b0; i_cfg_data = '0;
        i_cmd = cpt_pkg::CMD_LOAD; i_vertex_index = '0; i_vertex_x = '0; i_vertex_y = '0;
        i_scale_x = '0; i_scale_y = '0; i_pos_x = '0; i_pos_y = '0;
        i_angle = '0; i_point_x = '0; i_point_y = '0;
        errors = 0; quiet = 0; hold_req = 0;
        vert_count = '0; wld_count = 0;
        bb_mnx = '0; bb_mny = '0; bb_mxx = '0; bb_mxy = '0;
        for (i = 0; i < NV; i++) begin
            loc_x[i] = 0; loc_y[i] = 0; wld_x[i] = 0; wld_y[i] = 0;
            loc_written[i] = 0;
        end
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed table, part one, with no vertices in use: every test is
        // inside and the box stays at zero, so the answers are typed in.
        add_row(make_item(cpt_pkg::CMD_TEST, 0, 0, 0, 0), 1, 1, 0);
        add_row(make_item(cpt_pkg::CMD_TEST, 0, 32'sh7FFF_FFFF, 32'sh8000_0000, 0),
                1, 1, 0);
        add_row(make_item(cpt_pkg::CMD_TRANSFORM, 0, 32'sh7FFF_FFFF, 32'sh8000_0000,
                          25736), 1, 0, 0);
        add_row(make_item(cpt_pkg::CMD_SCALE, 0, 32'sh8000_0000, 32'sh7FFF_FFFF, 0),
                1, 0, 0);
        add_row(make_item(cpt_pkg::CMD_LOAD, 0, 32'sh7FFF_FFFF, 32'sh8000_0000, 0),
                1, 0, 0);
        add_row(make_item(cpt_pkg::CMD_LOAD, 1, -1, 1, 0), 1, 0, 0);
        add_row(make_item(cpt_pkg::CMD_LOAD, 2, 32'sh0001_0000, 0, 0), 1, 0, 0);
        add_row(make_item(cpt_pkg::CMD_LOAD, 3, 0, 32'sh0001_0000, 0), 1, 0, 0);
        add_row(make_item(cpt_pkg::CMD_LOAD, 31, 32'sh8000_0000, 32'sh7FFF_FFFF, 0),
                1, 0, 0);
        foreach (table_rows[r]) send_beat(table_rows[r].it, table_rows[r].known,
                                          table_rows[r].res);
        table_rows.delete();

        // Part two, four vertices: angle extremes and out-of-range angles,
        // saturating scale and translation, a zero-length edge and a point
        // lying exactly on an edge.
        write_count(6'd4);
        add_row(make_item(cpt_pkg::CMD_TRANSFORM, 0, 0, 0, 0), 0, 0, 0);
        add_row(make_item(cpt_pkg::CMD_TEST, 0, 0, 0, 0), 0, 0, 0);
        add_row(make_item(cpt_pkg::CMD_TRANSFORM, 0, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF,
                          16'sh7FFF), 0, 0, 0);
        add_row(make_item(cpt_pkg::CMD_TRANSFORM, 0, 32'sh8000_0000, 32'sh8000_0000,
                          16'sh8000), 0, 0, 0);
        add_row(make_item(cpt_pkg::CMD_TRANSFORM, 0, 0, 0, -25736), 0, 0, 0);
        add_row(make_item(cpt_pkg::CMD_TRANSFORM, 0, 0, 0, 20000), 0, 0, 0);
        add_row(make_item(cpt_pkg::CMD_SCALE, 0, 32'sh7FFF_FFFF, 32'sh8000_0000, 0),
                0, 0, 0);
        add_row(make_item(cpt_pkg::CMD_LOAD, 0, 0, 0, 0), 0, 0, 0);
        add_row(make_item(cpt_pkg::CMD_LOAD, 1, 0, 0, 0), 0, 0, 0);
        add_row(make_item(cpt_pkg::CMD_LOAD, 2, 32'sh0010_0000, 0, 0), 0, 0, 0);
        add_row(make_item(cpt_pkg::CMD_LOAD, 3, 0, 32'sh0010_0000, 0), 0, 0, 0);
        add_row(make_item(cpt_pkg::CMD_TRANSFORM, 0, 0, 0, 0), 0, 0, 0);
        add_row(make_item(cpt_pkg::CMD_TEST, 0, 32'sh0008_0000, 0, 0), 0, 0, 0);
        add_row(make_item(cpt_pkg::CMD_TEST, 0, 32'sh0004_0000, 32'sh0004_0000, 0),
                0, 0, 0);
        add_row(make_item(cpt_pkg::CMD_TEST, 0, -1, -1, 0), 0, 0, 0);
        foreach (table_rows[r]) send_beat(table_rows[r].it, table_rows[r].known,
                                          table_rows[r].res);

        // Random phases through several vertex counts, a count above the
        // store size among them. The long hold-off falls in the second one.
        random_phase(6'd3, 50);
        hold_req = 1;
        random_phase(6'd32, 50);
        random_phase(6'd63, 45);
        random_phase(6'd0, 30);
        random_phase(6'($urandom_range(1, 32)), 50);
        random_phase(6'd17, 50);
        random_phase(6'd5, 50);
        quiet = 1;
        random_phase(6'd4, 40);
        i_valid <= 1'b0;

        wait (pending_boxes.size() == 0);
        repeat (300) @(posedge i_clk);
        if (errors == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

    // Downstream: random stall bursts, plus one long hold-off on request.
    int stall_left;
    int hold_left;
    initial begin
        stall_left = 0;
        hold_left  = 0;
    end
    always @(posedge i_clk) begin
        if (hold_req && hold_left == 0) begin
            hold_left = HOLD_LEN;
            hold_req  = 0;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_stall <= 1'b1;
        end else if (quiet) begin
            i_stall <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left--;
            i_stall <= 1'b1;
        end else if ($urandom_range(0, 5) == 0) begin
            stall_left = $urandom_range(0, 7);
            i_stall <= 1'b1;
        end else begin
            i_stall <= 1'b0;
        end
    end

    // Result checker: every accepted beat against the oldest expectation.
    always @(posedge i_clk) begin
        box_res_t e;
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_boxes.size() == 0) begin
                $display("%0t: result beat with nothing expected", $time);
                errors++;
            end else begin
                e = pending_boxes.pop_front();
                if (o_inside_res !== e.hit || o_min_x !== e.mnx ||
                    o_min_y !== e.mny || o_max_x !== e.mxx || o_max_y !== e.mxy) begin
                    $display("%0t: mismatch expected inside=%0b box=(%0d,%0d)-(%0d,%0d)",
                             $time, e.hit, e.mnx, e.mny, e.mxx, e.mxy);
                    $display("%0t:            actual inside=%0b box=(%0d,%0d)-(%0d,%0d)",
                             $time, o_inside_res, o_min_x, o_min_y, o_max_x, o_max_y);
                    errors++;
                end
            end
        end
    end

    // Watchdog: too long without any beat accepted on any channel.
    int idle_cycles = 0;
    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall) || (i_cfg_valid && o_cfg_ready)
            || !i_rst_n) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
        end
        if (idle_cycles > WD_MAX) begin
            $display("Some tests failed");
            $finish;
        end
    end

endmodule
